### src/pks_pkg.sv
// ----------------------------------------------------------------------------
// Pancake sorter package
// Sizes, sequencer states and the structs passed between the sorter modules.
// ----------------------------------------------------------------------------
package pks_pkg;

   localparam int MAX_ITEMS  = 16;
   localparam int VALUE_BITS = 16;
   localparam int PORT_BITS  = 16;
   localparam int FLIP_BITS  = 5;
   localparam int IDX_BITS   = $clog2(MAX_ITEMS);
   localparam int CNT_BITS   = $clog2(MAX_ITEMS + 1);

   typedef logic [VALUE_BITS-1:0] value_type;
   typedef logic [IDX_BITS-1:0]   idx_type;
   typedef logic [CNT_BITS-1:0]   cnt_type;
   typedef logic [FLIP_BITS-1:0]  flip_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_SCAN_END,
      S_FLIP_RD,
      S_FLIP_WA,
      S_FLIP_WB,
      S_OUT
   } state_type;

   typedef struct packed {
      logic      we;
      idx_type   waddr;
      value_type wdata;
      idx_type   raddr_a;
      idx_type   raddr_b;
   } ram_ctl_type;

   typedef struct packed {
      logic     valid;
      logic     last;
      flip_type flips;
   } emit_type;

endpackage

### src/pks_stack_ram.sv
// ----------------------------------------------------------------------------
// Pancake sorter stack memory
// One write port and two read ports with registered read data.
// ----------------------------------------------------------------------------
module pks_stack_ram
   import pks_pkg::*;
(
   input  logic        clock,
   input  ram_ctl_type ctl,
   output value_type   rd_a,
   output value_type   rd_b
);

   value_type mem [MAX_ITEMS];
   value_type rd_a_ff;
   value_type rd_b_ff;

   always_ff @(posedge clock) begin
      if (ctl.we) begin
         mem[ctl.waddr] <= ctl.wdata;
      end
      rd_a_ff <= mem[ctl.raddr_a];
      rd_b_ff <= mem[ctl.raddr_b];
   end

   assign rd_a = rd_a_ff;
   assign rd_b = rd_b_ff;

endmodule

### src/pks_ctrl.sv
// ----------------------------------------------------------------------------
// Pancake sorter sequencer
// Loads the stack, runs max scans and prefix flips over the stack memory
// with one shared comparator, then reads the sorted stack out.
// ----------------------------------------------------------------------------
module pks_ctrl
   import pks_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  logic [PORT_BITS-1:0] item_value,
   input  logic            last_in,
   input  value_type       rd_a,
   input  value_type       rd_b,
   output logic            busy,
   output ram_ctl_type     ram_ctl,
   output emit_type        emit
);

   state_type state_ff, state_in;
   cnt_type   count_ff, count_in;
   idx_type   top_ff, top_in;
   idx_type   ptr_ff, ptr_in;
   idx_type   best_ff, best_in;
   value_type best_val_ff, best_val_in;
   idx_type   lo_ff, lo_in;
   idx_type   hi_ff, hi_in;
   flip_type  flip_ff, flip_in;
   logic      pend_ff, pend_in;
   idx_type   tag_ff, tag_in;
   logic      tag_vld_ff, tag_vld_in;

   logic      greater;
   idx_type   best_n;
   logic      swaps_left;
   cnt_type   n_load;

   assign greater    = rd_a > best_val_ff;
   assign swaps_left = ({1'b0, lo_ff} + (IDX_BITS+1)'(2)) < {1'b0, hi_ff};
   assign n_load     = (count_ff < CNT_BITS'(MAX_ITEMS)) ? count_ff + CNT_BITS'(1) : count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         count_ff   <= '0;
         flip_ff    <= '0;
         pend_ff    <= 1'b0;
         tag_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         flip_ff    <= flip_in;
         pend_ff    <= pend_in;
         tag_vld_ff <= tag_vld_in;
      end
      top_ff      <= top_in;
      ptr_ff      <= ptr_in;
      best_ff     <= best_in;
      best_val_ff <= best_val_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      tag_ff      <= tag_in;
   end

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      top_in      = top_ff;
      ptr_in      = ptr_ff;
      best_in     = best_ff;
      best_val_in = best_val_ff;
      lo_in       = lo_ff;
      hi_in       = hi_ff;
      flip_in     = flip_ff;
      pend_in     = pend_ff;
      tag_in      = tag_ff;
      tag_vld_in  = 1'b0;
      best_n      = best_ff;
      ram_ctl     = '0;
      ram_ctl.raddr_a = ptr_ff;
      ram_ctl.raddr_b = hi_ff;
      ram_ctl.wdata   = item_value[VALUE_BITS-1:0];
      ram_ctl.waddr   = count_ff[IDX_BITS-1:0];
      emit        = '0;
      emit.flips  = flip_ff;

      // fold the returning read beat into the running maximum
      if ((state_ff == S_SCAN || state_ff == S_SCAN_END) && tag_vld_ff) begin
         if (tag_ff == top_ff || greater) begin
            best_in     = tag_ff;
            best_val_in = rd_a;
            best_n      = tag_ff;
         end
      end

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               if (count_ff < CNT_BITS'(MAX_ITEMS)) begin
                  ram_ctl.we = 1'b1;
               end
               count_in = n_load;
               if (last_in) begin
                  flip_in = '0;
                  pend_in = 1'b0;
                  top_in  = IDX_BITS'(n_load - CNT_BITS'(1));
                  ptr_in  = IDX_BITS'(n_load - CNT_BITS'(1));
                  if (n_load == CNT_BITS'(1)) begin
                     ptr_in   = '0;
                     state_in = S_OUT;
                  end else begin
                     state_in = S_SCAN;
                  end
               end
            end
         end
         S_SCAN: begin
            tag_in     = ptr_ff;
            tag_vld_in = 1'b1;
            if (ptr_ff == '0) begin
               state_in = S_SCAN_END;
            end else begin
               ptr_in = ptr_ff - IDX_BITS'(1);
            end
         end
         S_SCAN_END: begin
            lo_in = '0;
            if (best_n == top_ff) begin
               top_in = top_ff - IDX_BITS'(1);
               ptr_in = top_ff - IDX_BITS'(1);
               if (top_ff == IDX_BITS'(1)) begin
                  ptr_in   = '0;
                  state_in = S_OUT;
               end else begin
                  state_in = S_SCAN;
               end
            end else if (best_n != '0) begin
               hi_in    = best_n;
               pend_in  = 1'b1;
               state_in = S_FLIP_RD;
            end else begin
               hi_in    = top_ff;
               pend_in  = 1'b0;
               state_in = S_FLIP_RD;
            end
         end
         S_FLIP_RD: begin
            ram_ctl.raddr_a = lo_ff;
            state_in        = S_FLIP_WA;
         end
         S_FLIP_WA: begin
            ram_ctl.raddr_a = lo_ff;
            ram_ctl.we      = 1'b1;
            ram_ctl.waddr   = lo_ff;
            ram_ctl.wdata   = rd_b;
            state_in        = S_FLIP_WB;
         end
         S_FLIP_WB: begin
            ram_ctl.raddr_a = lo_ff;
            ram_ctl.we      = 1'b1;
            ram_ctl.waddr   = hi_ff;
            ram_ctl.wdata   = rd_a;
            if (swaps_left) begin
               lo_in    = lo_ff + IDX_BITS'(1);
               hi_in    = hi_ff - IDX_BITS'(1);
               state_in = S_FLIP_RD;
            end else begin
               flip_in = flip_ff + FLIP_BITS'(1);
               lo_in   = '0;
               if (pend_ff) begin
                  pend_in  = 1'b0;
                  hi_in    = top_ff;
                  state_in = S_FLIP_RD;
               end else begin
                  top_in = top_ff - IDX_BITS'(1);
                  ptr_in = top_ff - IDX_BITS'(1);
                  if (top_ff == IDX_BITS'(1)) begin
                     ptr_in   = '0;
                     state_in = S_OUT;
                  end else begin
                     state_in = S_SCAN;
                  end
               end
            end
         end
         S_OUT: begin
            emit.valid = 1'b1;
            emit.last  = (CNT_BITS'(ptr_ff) + CNT_BITS'(1)) == count_ff;
            ptr_in     = ptr_ff + IDX_BITS'(1);
            if (emit.last) begin
               count_in = '0;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign busy = state_ff != S_IDLE;

   a_last_ends_run: assert property (@(posedge clock) disable iff (reset)
      emit.valid && emit.last |=> state_ff == S_IDLE)
      else $error("run did not end after final beat");

   a_flip_order: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_FLIP_RD |-> lo_ff < hi_ff)
      else $error("flip pointers crossed");

   a_flip_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_FLIP_RD |-> hi_ff <= top_ff)
      else $error("flip reaches past the top position");

endmodule

### src/pancake_sorter.sv
// ----------------------------------------------------------------------------
// Pancake sorter
// Collects a stack of values and returns it sorted in ascending order.
// ----------------------------------------------------------------------------
// Values arrive one per beat on start/req_*, the final one marked by
// req_last_in; up to 16 are kept and further values are dropped. On the final
// beat the block raises busy and pancake-sorts the stack in its memory: a max
// scan runs over positions 0..i, and each prefix flip swaps one pair at a time
// by reading both values and writing them back in turn through the single
// memory write port. For a stack of N values it then returns N beats, one per
// cycle, each with the flip count and the final one marked; busy drops in the
// same cycle that carries the final rsp_strobe beat, so the next stack may
// start while that beat is on the ports. The receiver cannot stall: every
// rsp_strobe beat must be taken as it appears.
// ----------------------------------------------------------------------------
module pancake_sorter
   import pks_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [PORT_BITS-1:0] req_item_value,
   input  logic                 req_last_in,
   output logic                 rsp_strobe,
   output logic [PORT_BITS-1:0] rsp_sorted_value,
   output logic [FLIP_BITS-1:0] rsp_flip_total,
   output logic                 rsp_last_out
);

   ram_ctl_type ram_ctl;
   emit_type    emit;
   value_type   rd_a;
   value_type   rd_b;

   logic     strobe_ff;
   logic     last_ff;
   flip_type flips_ff;

   pks_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .item_value (req_item_value),
      .last_in    (req_last_in),
      .rd_a       (rd_a),
      .rd_b       (rd_b),
      .busy       (busy),
      .ram_ctl    (ram_ctl),
      .emit       (emit)
   );

   pks_stack_ram u_ram (
      .clock (clock),
      .ctl   (ram_ctl),
      .rd_a  (rd_a),
      .rd_b  (rd_b)
   );

   // align beat markers with the registered read data
   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
         last_ff   <= 1'b0;
      end else begin
         strobe_ff <= emit.valid;
         last_ff   <= emit.valid && emit.last;
      end
      flips_ff <= emit.flips;
   end

   assign rsp_strobe       = strobe_ff;
   assign rsp_last_out     = last_ff;
   assign rsp_flip_total   = flips_ff;
   assign rsp_sorted_value = PORT_BITS'(rd_a);

   a_ascending: assert property (@(posedge clock) disable iff (reset)
      strobe_ff && $past(strobe_ff) && !$past(last_ff) |-> rd_a >= $past(rd_a))
      else $error("sorted beats out of order");

   a_flips_steady: assert property (@(posedge clock) disable iff (reset)
      strobe_ff && $past(strobe_ff) && !$past(last_ff) |-> $stable(flips_ff))
      else $error("flip count changed within a run");

endmodule
